>>> hw/rtl/qcosf_pkg.sv
// Shared constants, register index codes and helpers for the quad corner
// order and scale filter. No dependencies.
package qcosf_pkg;

   localparam int RATIO_W   = 16;   // Q4.12 ratio register width
   localparam int SIZE_W    = 13;   // image size register width
   localparam int CSR_IDX_W = 2;
   localparam int LANES     = 8;    // tl/tr/br/bl x, then tl/tr/br/bl y
   localparam int MIN_SIDE  = 5;    // edge with either delta >= this always passes
   localparam int MIN_SQ    = 25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATIO_W = 2'd0,
      CSR_RATIO_H = 2'd1,
      CSR_IMG_W   = 2'd2,
      CSR_IMG_H   = 2'd3
   } csr_index_type;

   // tests whether the squared length of a short edge, both deltas below MIN_SIDE, is below MIN_SQ
   function automatic logic sq_small(input logic [2:0] dx, input logic [2:0] dy);
      logic [6:0] sq;
      sq = 7'(dx) * 7'(dx) + 7'(dy) * 7'(dy);
      return sq < 7'(MIN_SQ);
   endfunction

endpackage

>>> hw/rtl/qcosf_front.sv
// Front end: stable sort of four corners by x, then y order inside the left
// and right pairs. Pure logic ahead of the queue. Uses qcosf_pkg.
module qcosf_front #(
   parameter int COORD_BITS = 12
) (
   input  logic [3:0][COORD_BITS-1:0]               x,
   input  logic [3:0][COORD_BITS-1:0]               y,
   output logic [qcosf_pkg::LANES-1:0][COORD_BITS-1:0] lanes
);
   import qcosf_pkg::*;

   logic [3:0][1:0]            rank;
   logic [3:0][COORD_BITS-1:0] sx, sy;
   logic                       swap_l, swap_r;

   // rank: earlier points with x <= own go first, later ones only when x < own
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rank[i] = '0;
         for (int j = 0; j < 4; j++) begin
            if (j < i && x[j] <= x[i]) rank[i] = rank[i] + 2'd1;
            if (j > i && x[j] <  x[i]) rank[i] = rank[i] + 2'd1;
         end
      end
      sx = '0;
      sy = '0;
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < 4; i++) begin
            if (rank[i] == 2'(p)) begin
               sx[p] = x[i];
               sy[p] = y[i];
            end
         end
      end
      swap_l = sy[0] > sy[1];
      swap_r = sy[2] > sy[3];
      // tl, tr, br, bl
      lanes[0] = swap_l ? sx[1] : sx[0];
      lanes[1] = swap_r ? sx[3] : sx[2];
      lanes[2] = swap_r ? sx[2] : sx[3];
      lanes[3] = swap_l ? sx[0] : sx[1];
      lanes[4] = swap_l ? sy[1] : sy[0];
      lanes[5] = swap_r ? sy[3] : sy[2];
      lanes[6] = swap_r ? sy[2] : sy[3];
      lanes[7] = swap_l ? sy[0] : sy[1];
   end

endmodule

>>> hw/rtl/qcosf_queue.sv
// Two-word queue between the sorting front end and the scaling back end.
// Uses qcosf_pkg.
module qcosf_queue #(
   parameter int WIDTH = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   import qcosf_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign rdata   = mem_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) mem_ff[wptr_ff] <= wdata;
   end

endmodule

>>> hw/rtl/qcosf_back.sv
// Back end: pipelined restoring dividers (one quotient bit per stage, eight
// lanes), clamp, short edge filter and output register. Uses qcosf_pkg.
module qcosf_back #(
   parameter int COORD_BITS      = 12,
   parameter int RATIO_FRAC_BITS = 12
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [qcosf_pkg::RATIO_W-1:0]               ratio_w,
   input  logic [qcosf_pkg::RATIO_W-1:0]               ratio_h,
   input  logic [qcosf_pkg::SIZE_W-1:0]                img_w,
   input  logic [qcosf_pkg::SIZE_W-1:0]                img_h,
   input  logic                                        in_valid,
   input  logic [qcosf_pkg::LANES-1:0][COORD_BITS-1:0] in_lanes,
   output logic                                        in_take,
   output logic                                        out_valid,
   input  logic                                        out_pop,
   output logic [qcosf_pkg::LANES-1:0][COORD_BITS-1:0] out_lanes,
   output logic [COORD_BITS-1:0]                       lim_x,
   output logic [COORD_BITS-1:0]                       lim_y,
   output logic                                        stall
);
   import qcosf_pkg::*;

   localparam int DW = COORD_BITS + RATIO_FRAC_BITS;
   localparam int CW = DW + RATIO_W;
   localparam int LW = SIZE_W + COORD_BITS;

   logic [LANES-1:0][DW-1:0]         rem_ff [COORD_BITS];
   logic [LANES-1:0][DW-1:0]         rem_in [COORD_BITS];
   logic [LANES-1:0][COORD_BITS-1:0] q_ff   [COORD_BITS+1];
   logic [LANES-1:0][COORD_BITS-1:0] q_in   [COORD_BITS+1];
   logic [LANES-1:0]                 sat_ff [COORD_BITS+1];
   logic [LANES-1:0]                 sat_in [COORD_BITS+1];
   logic [COORD_BITS:0]              vld_ff, vld_in;

   logic [LANES-1:0][COORD_BITS-1:0] cl_ff, cl_in, out_ff, out_in;
   logic                             cl_vld_ff, cl_vld_in, out_vld_ff, out_vld_in;
   logic                             keep, advance;
   logic [COORD_BITS-1:0]            dx_t, dy_t, dx_l, dy_l;

   function automatic logic [COORD_BITS-1:0] limit(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] m1;
      m1 = size - SIZE_W'(1);
      if (size == '0) return '0;
      if (LW'(m1) > LW'({COORD_BITS{1'b1}})) return {COORD_BITS{1'b1}};
      return COORD_BITS'(m1);
   endfunction

   function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic edge_short(input logic [COORD_BITS-1:0] dx,
                                       input logic [COORD_BITS-1:0] dy);
      if (dx >= COORD_BITS'(MIN_SIDE) || dy >= COORD_BITS'(MIN_SIDE)) return 1'b0;
      return sq_small(dx[2:0], dy[2:0]);
   endfunction

   assign lim_x     = limit(img_w);
   assign lim_y     = limit(img_h);
   assign out_valid = out_vld_ff;
   assign out_lanes = out_ff;
   assign stall     = cl_vld_ff && keep && out_vld_ff && !out_pop;
   assign advance   = !stall;
   assign in_take   = advance;

   // stage 0: dividend, overflow test against ratio << COORD_BITS
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [RATIO_W-1:0] r;
         logic [DW-1:0]      d;
         r = (l < 4) ? ratio_w : ratio_h;
         d = {in_lanes[l], {RATIO_FRAC_BITS{1'b0}}};
         rem_in[0][l] = d;
         q_in[0][l]   = '0;
         sat_in[0][l] = CW'(d) >= CW'({r, {COORD_BITS{1'b0}}});
      end
      vld_in[0] = in_valid;
   end

   // one quotient bit per stage, most significant first
   for (genvar s = 1; s <= COORD_BITS; s++) begin : g_div
      localparam int K = COORD_BITS - s;
      logic [LANES-1:0] hit;
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            logic [CW-1:0] dvs;
            dvs    = CW'((l < 4) ? ratio_w : ratio_h) << K;
            hit[l] = CW'(rem_ff[s-1][l]) >= dvs;
            q_in[s][l] = q_ff[s-1][l] | (hit[l] ? (COORD_BITS'(1) << K) : '0);
            sat_in[s][l] = sat_ff[s-1][l];
         end
         vld_in[s] = vld_ff[s-1];
      end
      if (s < COORD_BITS) begin : g_rem
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_in[s][l] = hit[l] ? DW'(CW'(rem_ff[s-1][l]) -
                                           (CW'((l < 4) ? ratio_w : ratio_h) << K))
                                     : rem_ff[s-1][l];
            end
         end
      end
   end

   // clamp
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [COORD_BITS-1:0] lim, q;
         lim = (l < 4) ? lim_x : lim_y;
         q   = q_ff[COORD_BITS][l];
         cl_in[l] = (sat_ff[COORD_BITS][l] || q > lim) ? lim : q;
      end
      cl_vld_in = vld_ff[COORD_BITS];
   end

   // edge filter on top (tl-tr) and left (tl-bl) edges
   always_comb begin
      dx_t = absdiff(cl_ff[0], cl_ff[1]);
      dy_t = absdiff(cl_ff[4], cl_ff[5]);
      dx_l = absdiff(cl_ff[0], cl_ff[3]);
      dy_l = absdiff(cl_ff[4], cl_ff[7]);
      keep = !edge_short(dx_t, dy_t) && !edge_short(dx_l, dy_l);
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !out_pop;
      if (advance && cl_vld_ff && keep) begin
         out_in     = cl_ff;
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         cl_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (advance) begin
            vld_ff    <= vld_in;
            cl_vld_ff <= cl_vld_in;
         end
      end
      out_ff <= out_in;
      if (advance) begin
         for (int s = 0; s < COORD_BITS; s++) rem_ff[s] <= rem_in[s];
         for (int s = 0; s <= COORD_BITS; s++) begin
            q_ff[s]   <= q_in[s];
            sat_ff[s] <= sat_in[s];
         end
         cl_ff <= cl_in;
      end
   end

endmodule

>>> hw/rtl/quad_corner_order_scale_filter.sv
// Quad corner order, scale and size filter. One quadrilateral word per cycle
// enters through req_push/req_full; it is sorted into top-left, top-right,
// bottom-right, bottom-left order, each coordinate divided by its Q4.12 ratio
// (truncated), clamped to the image, and dropped when the top or left edge is
// shorter than 5 pixels. Surviving boxes come out through rsp_empty/rsp_pop.
// Throughput is one word per clock while the back pipe is not held; the
// restoring dividers resolve one quotient bit per pipeline stage across eight
// lanes. A two-word queue sits between the sorter and the divider pipe; the
// whole back pipe holds only while a kept box waits in the clamp register
// behind an unpopped word in the output register. Configuration (csr_index
// 0: ratio_w_q12, 1: ratio_h_q12, 2: image_width, 3: image_height) is always
// ready and must be written while the block is idle. Depends on qcosf_pkg,
// qcosf_front, qcosf_queue, qcosf_back.
module quad_corner_order_scale_filter #(
   parameter int COORD_BITS      = 12,
   parameter int RATIO_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [COORD_BITS-1:0] req_in_x0,
   input  logic [COORD_BITS-1:0] req_in_y0,
   input  logic [COORD_BITS-1:0] req_in_x1,
   input  logic [COORD_BITS-1:0] req_in_y1,
   input  logic [COORD_BITS-1:0] req_in_x2,
   input  logic [COORD_BITS-1:0] req_in_y2,
   input  logic [COORD_BITS-1:0] req_in_x3,
   input  logic [COORD_BITS-1:0] req_in_y3,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COORD_BITS-1:0] rsp_top_left_x,
   output logic [COORD_BITS-1:0] rsp_top_left_y,
   output logic [COORD_BITS-1:0] rsp_top_right_x,
   output logic [COORD_BITS-1:0] rsp_top_right_y,
   output logic [COORD_BITS-1:0] rsp_bottom_right_x,
   output logic [COORD_BITS-1:0] rsp_bottom_right_y,
   output logic [COORD_BITS-1:0] rsp_bottom_left_x,
   output logic [COORD_BITS-1:0] rsp_bottom_left_y,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [qcosf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qcosf_pkg::RATIO_W-1:0]   csr_data
);
   import qcosf_pkg::*;

   localparam int QW = LANES * COORD_BITS;

   // config registers
   logic [RATIO_W-1:0] ratio_w_ff, ratio_w_in, ratio_h_ff, ratio_h_in;
   logic [SIZE_W-1:0]  img_w_ff, img_w_in, img_h_ff, img_h_in;

   logic [LANES-1:0][COORD_BITS-1:0] sorted, q_lanes, out_lanes;
   logic [QW-1:0]                    q_rdata;
   logic                             q_empty, take, out_valid, stall;
   logic [COORD_BITS-1:0]            lim_x, lim_y;

   assign csr_ready = 1'b1;

   always_comb begin
      ratio_w_in = ratio_w_ff;
      ratio_h_in = ratio_h_ff;
      img_w_in   = img_w_ff;
      img_h_in   = img_h_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RATIO_W: ratio_w_in = csr_data;
            CSR_RATIO_H: ratio_h_in = csr_data;
            CSR_IMG_W:   img_w_in   = csr_data[SIZE_W-1:0];
            CSR_IMG_H:   img_h_in   = csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_w_ff <= RATIO_W'(4096);
         ratio_h_ff <= RATIO_W'(4096);
         img_w_ff   <= SIZE_W'(4096);
         img_h_ff   <= SIZE_W'(4096);
      end else begin
         ratio_w_ff <= ratio_w_in;
         ratio_h_ff <= ratio_h_in;
         img_w_ff   <= img_w_in;
         img_h_ff   <= img_h_in;
      end
   end

   // front: sort on the way into the queue
   qcosf_front #(.COORD_BITS(COORD_BITS)) u_front (
      .x     ({req_in_x3, req_in_x2, req_in_x1, req_in_x0}),
      .y     ({req_in_y3, req_in_y2, req_in_y1, req_in_y0}),
      .lanes (sorted)
   );

   qcosf_queue #(.WIDTH(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (sorted),
      .full  (req_full),
      .pop   (take),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   assign q_lanes = q_rdata;

   // back: divide, clamp, filter, output register
   qcosf_back #(
      .COORD_BITS      (COORD_BITS),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ratio_w   (ratio_w_ff),
      .ratio_h   (ratio_h_ff),
      .img_w     (img_w_ff),
      .img_h     (img_h_ff),
      .in_valid  (!q_empty),
      .in_lanes  (q_lanes),
      .in_take   (take),
      .out_valid (out_valid),
      .out_pop   (rsp_pop),
      .out_lanes (out_lanes),
      .lim_x     (lim_x),
      .lim_y     (lim_y),
      .stall     (stall)
   );

   assign rsp_empty          = !out_valid;
   assign rsp_top_left_x     = out_lanes[0];
   assign rsp_top_right_x    = out_lanes[1];
   assign rsp_bottom_right_x = out_lanes[2];
   assign rsp_bottom_left_x  = out_lanes[3];
   assign rsp_top_left_y     = out_lanes[4];
   assign rsp_top_right_y    = out_lanes[5];
   assign rsp_bottom_right_y = out_lanes[6];
   assign rsp_bottom_left_y  = out_lanes[7];

`ifndef SYNTHESIS
   // back pipe only holds behind a waiting word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      stall |-> !rsp_empty && !rsp_pop)
      else $error("back pipe stalled without a waiting result");

   // top-left and bottom-right results respect the clamp limits
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_top_left_x <= lim_x && rsp_bottom_right_x <= lim_x &&
                     rsp_top_left_y <= lim_y && rsp_bottom_right_y <= lim_y)
      else $error("result outside image limits");

   // scaling is monotonic, so the left pair stays ordered by y
   a_top_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_top_left_y <= rsp_bottom_left_y)
      else $error("left pair not ordered by y");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for quad_corner_order_scale_filter: corner ordering, rescale, clamp and
// small-box drop, checked word by word against an in-bench predictor. Depends on qcosf_pkg.
module tb_top;
   import qcosf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB        = 12;
   localparam int LATENCY   = CB + 3;
   localparam int DRAIN_CYC = 4 * LATENCY;   // quiet time before a csr write
   localparam longint LIMIT = 2_000_000;

   typedef logic [CB-1:0] coord_t;
   typedef struct packed { coord_t x, y; } corner_t;
   typedef struct packed { corner_t tl, tr, br, bl; } box_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   coord_t req_in_x0 = '0, req_in_y0 = '0, req_in_x1 = '0, req_in_y1 = '0;
   coord_t req_in_x2 = '0, req_in_y2 = '0, req_in_x3 = '0, req_in_y3 = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   coord_t rsp_top_left_x, rsp_top_left_y, rsp_top_right_x, rsp_top_right_y;
   coord_t rsp_bottom_right_x, rsp_bottom_right_y, rsp_bottom_left_x, rsp_bottom_left_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_RATIO_W;
   logic [RATIO_W-1:0] csr_data = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quad_corner_order_scale_filter dut (.*);

   // predictor copy of the four registers
   logic [RATIO_W-1:0] ratio_w, ratio_h;
   logic [SIZE_W-1:0]  img_w, img_h;

   box_t   kept_boxes[$];     // boxes still owed by the block
   int     errors = 0;
   int     sent = 0, dropped = 0, popped = 0;
   longint cycles = 0;
   int     send_idle_pct = 0, pop_stall_pct = 0;

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, popped);
   endtask

   // clamp limit from an image size register
   function automatic coord_t size_limit(input logic [SIZE_W-1:0] size);
      if (size == 0) return '0;
      if (size - 1 > (1 << CB) - 1) return '1;
      return coord_t'(size - 1);
   endfunction

   function automatic coord_t rescale(input coord_t v, input logic [RATIO_W-1:0] r,
                                      input logic [SIZE_W-1:0] size);
      coord_t lim;
      longint q;
      lim = size_limit(size);
      if (r == 0) return lim;
      q = (longint'(v) << 12) / r;
      return (q > lim) ? lim : coord_t'(q);
   endfunction

   function automatic longint edge_sq(input corner_t a, input corner_t b);
      longint dx, dy;
      dx = (a.x > b.x) ? a.x - b.x : b.x - a.x;
      dy = (a.y > b.y) ? a.y - b.y : b.y - a.y;
      return dx * dx + dy * dy;
   endfunction

   // order, rescale and filter one quad; returns 0 when the box is dropped
   function automatic bit order_and_scale(input corner_t pin[4], output box_t box);
      corner_t p[4];
      corner_t t;
      corner_t o[4];
      int j;
      p = pin;
      for (int i = 1; i < 4; i++) begin
         t = p[i];
         j = i - 1;
         while (j >= 0 && p[j].x > t.x) begin
            p[j+1] = p[j];
            j--;
         end
         p[j+1] = t;
      end
      if (p[0].y > p[1].y) begin t = p[0]; p[0] = p[1]; p[1] = t; end
      if (p[2].y > p[3].y) begin t = p[2]; p[2] = p[3]; p[3] = t; end
      o[0] = p[0]; o[1] = p[2]; o[2] = p[3]; o[3] = p[1];
      for (int i = 0; i < 4; i++) begin
         o[i].x = rescale(o[i].x, ratio_w, img_w);
         o[i].y = rescale(o[i].y, ratio_h, img_h);
      end
      box = {o[0], o[1], o[2], o[3]};
      return !(edge_sq(o[0], o[1]) < MIN_SQ || edge_sq(o[0], o[3]) < MIN_SQ);
   endfunction

   // push one quad word, idling first at the current sender rate;
   // push stays high for back to back words and drops in wait_idle
   task automatic send_quad(input corner_t c[4]);
      box_t b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push  <= 1'b1;
      req_in_x0 <= c[0].x; req_in_y0 <= c[0].y;
      req_in_x1 <= c[1].x; req_in_y1 <= c[1].y;
      req_in_x2 <= c[2].x; req_in_y2 <= c[2].y;
      req_in_x3 <= c[3].x; req_in_y3 <= c[3].y;
      do @(posedge clock); while (req_full);
      sent++;
      if (order_and_scale(c, b)) kept_boxes = {kept_boxes, b};
      else dropped++;
   endtask

   function automatic corner_t pt(input int x, input int y);
      return '{x: coord_t'(x), y: coord_t'(y)};
   endfunction

   // a random quad: mostly a real box near some origin, otherwise noise
   function automatic void random_quad(output corner_t c[4]);
      int x0, y0, w, h, k;
      k = $urandom_range(9);
      if (k < 2) begin
         foreach (c[i]) c[i] = pt($urandom, $urandom);
      end else begin
         x0 = $urandom_range(4095); y0 = $urandom_range(4095);
         w  = (k < 4) ? $urandom_range(8) : $urandom_range(400);
         h  = (k < 4) ? $urandom_range(8) : $urandom_range(400);
         c[0] = pt(x0, y0);
         c[1] = pt(x0 + w + $urandom_range(3) - 1, y0 + $urandom_range(2));
         c[2] = pt(x0 + w, y0 + h);
         c[3] = pt(x0 + ($urandom_range(1) ? 0 : $urandom_range(3)), y0 + h);
         // shuffle the corner order
         for (int i = 3; i > 0; i--) begin
            corner_t t;
            int j;
            j = $urandom_range(i);
            t = c[i]; c[i] = c[j]; c[j] = t;
         end
      end
   endfunction

   // stop pushing, wait until every owed box is popped, then let the pipe drain
   task automatic wait_idle();
      req_push <= 1'b0;
      wait (kept_boxes.size() == 0);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // valid stays high across back to back writes and drops in set_regs
   task automatic write_reg(input csr_index_type idx, input logic [RATIO_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RATIO_W: ratio_w = val;
         CSR_RATIO_H: ratio_h = val;
         CSR_IMG_W:   img_w = SIZE_W'(val);
         CSR_IMG_H:   img_h = SIZE_W'(val);
      endcase
   endtask

   task automatic set_regs(input int rw, input int rh, input int iw, input int ih);
      wait_idle();
      write_reg(CSR_RATIO_W, RATIO_W'(rw));
      write_reg(CSR_RATIO_H, RATIO_W'(rh));
      write_reg(CSR_IMG_W, RATIO_W'(iw));
      write_reg(CSR_IMG_H, RATIO_W'(ih));
      csr_valid <= 1'b0;
   endtask

   // directed corners: field extremes, x ties, y ties, drop thresholds
   task automatic test_directed();
      corner_t c[4];
      c = '{pt(0,0), pt(4095,0), pt(4095,4095), pt(0,4095)};        send_quad(c);
      c = '{pt(4095,4095), pt(0,4095), pt(0,0), pt(4095,0)};        send_quad(c);
      c = '{pt(10,10), pt(10,50), pt(10,20), pt(10,5)};             send_quad(c); // all x equal
      c = '{pt(100,30), pt(50,30), pt(100,30), pt(50,30)};          send_quad(c); // y ties
      c = '{pt(0,0), pt(3,4), pt(3,9), pt(0,5)};                    send_quad(c); // length 5 kept
      c = '{pt(0,0), pt(4,0), pt(4,9), pt(0,9)};                    send_quad(c); // top 4 dropped
      c = '{pt(0,0), pt(9,0), pt(9,4), pt(0,4)};                    send_quad(c); // left 4 dropped
      c = '{pt(2730,1365), pt(1365,2730), pt(2730,2730), pt(1365,1365)}; send_quad(c);
      c = '{pt(7,3), pt(7,3), pt(7,3), pt(7,3)};                    send_quad(c);
      c = '{pt(2048,2048), pt(2060,2049), pt(2061,2070), pt(2047,2069)}; send_quad(c);
   endtask

   task automatic test_config_extremes();
      corner_t c[4];
      // zero ratio saturates, unity-ish, maximal ratio, zero and oversize images
      int rw[6] = '{0, 1, 65535, 2048, 8192, 4096};
      int rh[6] = '{4096, 65535, 1, 0, 6000, 3000};
      int iw[6] = '{4096, 8191, 0, 640, 1, 5000};
      int ih[6] = '{4096, 0, 8191, 480, 4096, 1};
      for (int s = 0; s < 6; s++) begin
         set_regs(rw[s], rh[s], iw[s], ih[s]);
         test_directed();
         repeat (10) begin random_quad(c); send_quad(c); end
      end
   endtask

   // random quads over unity or random settings and idling phases
   task automatic test_random(input int n, input int idle_pct, input int stall_pct);
      corner_t c[4];
      wait_idle();
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      case ($urandom_range(2))
         0: set_regs(4096, 4096, 4096, 4096);
         1: set_regs($urandom_range(2048, 16384), $urandom_range(2048, 16384),
                     $urandom_range(1, 4096), $urandom_range(1, 4096));
         default: set_regs($urandom_range(65535), $urandom_range(65535),
                           $urandom_range(8191), $urandom_range(8191));
      endcase
      repeat (n) begin random_quad(c); send_quad(c); end
   endtask

   // result side: pop at random and compare against the oldest owed box
   always @(posedge clock) begin
      box_t want, got;
      cycles++;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_top_left_x, rsp_top_left_y, rsp_top_right_x, rsp_top_right_y,
                rsp_bottom_right_x, rsp_bottom_right_y,
                rsp_bottom_left_x, rsp_bottom_left_y};
         if (kept_boxes.size() == 0) report("unexpected word", 1, 0);
         else begin
            want = kept_boxes.pop_front();
            if (got.tl.x != want.tl.x) report("top_left_x", got.tl.x, want.tl.x);
            if (got.tl.y != want.tl.y) report("top_left_y", got.tl.y, want.tl.y);
            if (got.tr.x != want.tr.x) report("top_right_x", got.tr.x, want.tr.x);
            if (got.tr.y != want.tr.y) report("top_right_y", got.tr.y, want.tr.y);
            if (got.br.x != want.br.x) report("bottom_right_x", got.br.x, want.br.x);
            if (got.br.y != want.br.y) report("bottom_right_y", got.br.y, want.br.y);
            if (got.bl.x != want.bl.x) report("bottom_left_x", got.bl.x, want.bl.x);
            if (got.bl.y != want.bl.y) report("bottom_left_y", got.bl.y, want.bl.y);
         end
         popped++;
      end
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      ratio_w = 4096; ratio_h = 4096; img_w = 4096; img_h = 4096;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random(200, 0, 0);
      test_random(200, 60, 0);
      test_random(200, 0, 60);
      test_random(200, 22, 22);
      pop_stall_pct = 0;
      wait_idle();
      $display("covered %0d quads, %0d dropped, %0d boxes checked across register settings",
               sent, dropped, popped);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
